// ----- rtl/ohlc_pkg.sv -----
// Shared constants, codes and control structs for the OHLC window aggregator.
package ohlc_pkg;

    localparam int HOURS_PER_DAY_DEF     = 24;
    localparam int MAX_GROUP_SAMPLES_DEF = 131071;
    localparam int DAYS_PER_WEEK         = 7;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int TEMP_W  = 16;
    localparam int MODE_W  = 3;
    localparam int SIZE_W  = 4;
    localparam int SUM_W   = 32;
    localparam int DATE_W  = YEAR_W + MONTH_W + DAY_W;
    localparam int KEY_W   = YEAR_W + MONTH_W;
    localparam int KIG_W   = 4;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [KIG_W-1:0] KIG_MAX = 4'd15;

    localparam logic signed [TEMP_W-1:0] SEED_HIGH = -16'sd20000;
    localparam logic signed [TEMP_W-1:0] SEED_LOW  = 16'sd20000;

    localparam logic [MODE_W-1:0] MODE_DAYS      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WEEKS     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MONTHS    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_YEARS     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DAYS_DROP = 3'd4;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    localparam logic [1:0] REG_GROUP_MODE = 2'd0;
    localparam logic [1:0] REG_GROUP_SIZE = 2'd1;
    localparam logic [1:0] REG_START_YEAR = 2'd2;
    localparam logic [1:0] REG_END_YEAR   = 2'd3;

    localparam logic [SIZE_W-1:0] GROUP_SIZE_RST = 4'd1;
    localparam logic [YEAR_W-1:0] END_YEAR_RST   = 14'd9999;

    typedef struct packed {
        logic step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic close;
        logic div_done;
    } dp_status_t;

endpackage

// ----- rtl/ohlc_window_aggregator.sv -----
// Top level: APB register file, controller and datapath of the OHLC window aggregator.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  input    | in_valid / in_stall        | cmd, temperature, sample_year/month/day
//  output   | out_valid / out_stall      | first_year/month/day, open_mean,
//           |                            | close_mean, high_value, low_value
//  config   | psel/penable/pwrite/pready | paddr[3:2] selects register, pwdata/prdata
//
//  A request that closes a group updates the group state, runs the bit-serial
//  restoring divider for the mean, waits for the divider's done flag and then
//  loads the result.
//  Reset clears all group state and the control logic; no clearing pass.
//  The result register holds under out_stall; a further request is taken meanwhile,
//  but one that closes a group waits after its division until the register is free.
module ohlc_window_aggregator
    import ohlc_pkg::*;
#(
    parameter int HOURS_PER_DAY     = HOURS_PER_DAY_DEF,
    parameter int MAX_GROUP_SAMPLES = MAX_GROUP_SAMPLES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     cmd,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic [YEAR_W-1:0]        sample_year,
    input  logic [MONTH_W-1:0]       sample_month,
    input  logic [DAY_W-1:0]         sample_day,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [YEAR_W-1:0]        first_year,
    output logic [MONTH_W-1:0]       first_month,
    output logic [DAY_W-1:0]         first_day,
    output logic signed [TEMP_W-1:0] open_mean,
    output logic signed [TEMP_W-1:0] close_mean,
    output logic signed [TEMP_W-1:0] high_value,
    output logic signed [TEMP_W-1:0] low_value
);

    logic [MODE_W-1:0] group_mode_reg;
    logic [SIZE_W-1:0] group_size_reg;
    logic [YEAR_W-1:0] start_year_reg;
    logic [YEAR_W-1:0] end_year_reg;
    logic [1:0]        reg_idx;
    logic              wr_en;
    ctrl_cmd_t         cmd_ctl;
    dp_status_t        status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_mode_reg <= MODE_DAYS;
            group_size_reg <= GROUP_SIZE_RST;
            start_year_reg <= '0;
            end_year_reg   <= END_YEAR_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_GROUP_MODE: group_mode_reg <= pwdata[MODE_W-1:0];
                REG_GROUP_SIZE: group_size_reg <= pwdata[SIZE_W-1:0];
                REG_START_YEAR: start_year_reg <= pwdata[YEAR_W-1:0];
                REG_END_YEAR:   end_year_reg   <= pwdata[YEAR_W-1:0];
                default:        group_mode_reg <= group_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GROUP_MODE: prdata = APB_DW'(group_mode_reg);
            REG_GROUP_SIZE: prdata = APB_DW'(group_size_reg);
            REG_START_YEAR: prdata = APB_DW'(start_year_reg);
            REG_END_YEAR:   prdata = APB_DW'(end_year_reg);
            default:        prdata = '0;
        endcase
    end

    ohlc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd_ctl   (cmd_ctl)
    );

    ohlc_dp #(
        .HOURS_PER_DAY     (HOURS_PER_DAY),
        .MAX_GROUP_SAMPLES (MAX_GROUP_SAMPLES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_ctl      (cmd_ctl),
        .status       (status),
        .group_mode   (group_mode_reg),
        .group_size   (group_size_reg),
        .start_year   (start_year_reg),
        .end_year     (end_year_reg),
        .cmd          (cmd),
        .temperature  (temperature),
        .sample_year  (sample_year),
        .sample_month (sample_month),
        .sample_day   (sample_day),
        .first_year   (first_year),
        .first_month  (first_month),
        .first_day    (first_day),
        .open_mean    (open_mean),
        .close_mean   (close_mean),
        .high_value   (high_value),
        .low_value    (low_value)
    );

endmodule

// ----- rtl/ohlc_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned 32-bit dividend.
module ohlc_div
    import ohlc_pkg::*;
#(
    parameter int CW = 17
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CW-1:0]    divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [CW-1:0]    rem_reg;
    logic [CW-1:0]    rem_next;
    logic [SUM_W-1:0] quo_reg;
    logic [SUM_W-1:0] quo_next;
    logic [CW-1:0]    dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CW:0]      trial;
    logic [CW:0]      diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = diff[CW-1:0];
            quo_next = {quo_reg[SUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[CW-1:0];
            quo_next = {quo_reg[SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/ohlc_dp.sv -----
// Datapath: group accumulators, close decision, mean division and result register.
module ohlc_dp
    import ohlc_pkg::*;
#(
    parameter int HOURS_PER_DAY     = HOURS_PER_DAY_DEF,
    parameter int MAX_GROUP_SAMPLES = MAX_GROUP_SAMPLES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_cmd_t                cmd_ctl,
    output dp_status_t               status,
    input  logic [MODE_W-1:0]        group_mode,
    input  logic [SIZE_W-1:0]        group_size,
    input  logic [YEAR_W-1:0]        start_year,
    input  logic [YEAR_W-1:0]        end_year,
    input  logic                     cmd,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic [YEAR_W-1:0]        sample_year,
    input  logic [MONTH_W-1:0]       sample_month,
    input  logic [DAY_W-1:0]         sample_day,
    output logic [YEAR_W-1:0]        first_year,
    output logic [MONTH_W-1:0]       first_month,
    output logic [DAY_W-1:0]         first_day,
    output logic signed [TEMP_W-1:0] open_mean,
    output logic signed [TEMP_W-1:0] close_mean,
    output logic signed [TEMP_W-1:0] high_value,
    output logic signed [TEMP_W-1:0] low_value
);

    localparam int CW         = $clog2(MAX_GROUP_SAMPLES + 1);
    localparam int WEEK_HOURS = DAYS_PER_WEEK * HOURS_PER_DAY;
    localparam int TW         = SIZE_W + $clog2(WEEK_HOURS + 1);
    localparam int CMPW       = (TW > CW) ? TW : CW;

    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_GROUP_SAMPLES);

    // group state
    logic [CW-1:0]              count_reg, count_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [TEMP_W-1:0]   high_reg, high_next;
    logic signed [TEMP_W-1:0]   low_reg, low_next;
    logic [KIG_W-1:0]           kig_reg, kig_next;
    logic [KEY_W-1:0]           key_reg, key_next;
    logic [DATE_W-1:0]          date_reg, date_next;
    logic                       active_reg, active_next;
    logic                       hp_reg, hp_next;
    logic signed [TEMP_W-1:0]   prev_mean_reg;

    // closed-group snapshot
    logic                       snap_hp_reg;
    logic                       snap_neg_reg;
    logic                       snap_zero_reg;
    logic [DATE_W-1:0]          snap_date_reg;
    logic signed [TEMP_W-1:0]   snap_high_reg;
    logic signed [TEMP_W-1:0]   snap_low_reg;

    // result register
    logic [YEAR_W-1:0]          first_year_reg;
    logic [MONTH_W-1:0]         first_month_reg;
    logic [DAY_W-1:0]           first_day_reg;
    logic signed [TEMP_W-1:0]   open_reg;
    logic signed [TEMP_W-1:0]   close_reg;
    logic signed [TEMP_W-1:0]   high_out_reg;
    logic signed [TEMP_W-1:0]   low_out_reg;

    logic [SIZE_W-1:0]          size;
    logic [MODE_W-1:0]          mode;
    logic                       key_mode;
    logic                       year_ok;
    logic [KEY_W-1:0]           key;
    logic                       key_change;
    logic                       key_close;
    logic [DATE_W-1:0]          date_in;
    logic [TW-1:0]              mult_sel;
    logic [TW-1:0]              target;
    logic [CMPW-1:0]            tgt_ext;
    logic [CMPW-1:0]            tgt_sat;

    logic [CW-1:0]              base_count;
    logic signed [SUM_W-1:0]    base_sum;
    logic signed [TEMP_W-1:0]   base_high;
    logic signed [TEMP_W-1:0]   base_low;
    logic                       base_active;
    logic                       add_ok;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    sum_after;
    logic [CW-1:0]              count_after;
    logic signed [TEMP_W-1:0]   high_after;
    logic signed [TEMP_W-1:0]   low_after;
    logic                       count_close;

    logic                       close;
    logic signed [SUM_W-1:0]    snap_sum;
    logic [CW-1:0]              snap_count;
    logic signed [TEMP_W-1:0]   snap_high;
    logic signed [TEMP_W-1:0]   snap_low;
    logic [DATE_W-1:0]          snap_date;
    logic [SUM_W-1:0]           snap_mag;

    logic                       div_start;
    logic                       div_done;
    logic [SUM_W-1:0]           quotient;
    logic [SUM_W-1:0]           mean32;
    logic signed [TEMP_W-1:0]   mean16;

    always_comb
    begin
        size       = (group_size == '0) ? GROUP_SIZE_RST : group_size;
        mode       = (group_mode > MODE_DAYS_DROP) ? MODE_DAYS_DROP : group_mode;
        key_mode   = (mode == MODE_MONTHS) || (mode == MODE_YEARS);
        year_ok    = (sample_year >= start_year) && (sample_year <= end_year);
        key        = (mode == MODE_MONTHS) ? {sample_year, sample_month}
                                           : {{MONTH_W{1'b0}}, sample_year};
        key_change = active_reg && (key != key_reg);
        key_close  = key_mode && key_change && (kig_reg >= size);
        date_in    = {sample_year, sample_month, sample_day};

        mult_sel = (mode == MODE_WEEKS) ? TW'(WEEK_HOURS) : TW'(HOURS_PER_DAY);
        target   = TW'(size) * mult_sel;
        tgt_ext  = CMPW'(target);
        tgt_sat  = (tgt_ext > CMPW'(MAX_GROUP_SAMPLES)) ? CMPW'(MAX_GROUP_SAMPLES)
                                                        : tgt_ext;

        // a key change that closes the group starts the sample on a fresh group
        if (key_close)
        begin
            base_count  = '0;
            base_sum    = '0;
            base_high   = SEED_HIGH;
            base_low    = SEED_LOW;
            base_active = 1'b0;
        end
        else
        begin
            base_count  = count_reg;
            base_sum    = sum_reg;
            base_high   = high_reg;
            base_low    = low_reg;
            base_active = active_reg;
        end

        add_ok   = (base_count < COUNT_MAX);
        sum_wide = {base_sum[SUM_W-1], base_sum}
                 + {{(SUM_W + 1 - TEMP_W){temperature[TEMP_W-1]}}, temperature};
        if (!add_ok)
            sum_after = base_sum;
        else if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_after = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_after = sum_wide[SUM_W-1:0];
        count_after = base_count + CW'(add_ok);
        high_after  = (temperature > base_high) ? temperature : base_high;
        low_after   = (temperature < base_low) ? temperature : base_low;
        count_close = (CMPW'(count_after) >= tgt_sat);

        count_next  = count_reg;
        sum_next    = sum_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        kig_next    = kig_reg;
        key_next    = key_reg;
        date_next   = date_reg;
        active_next = active_reg;
        hp_next     = hp_reg;
        close       = 1'b0;
        snap_sum    = sum_reg;
        snap_count  = count_reg;
        snap_high   = high_reg;
        snap_low    = low_reg;
        snap_date   = date_reg;

        if (cmd == CMD_FLUSH)
        begin
            close       = active_reg && (mode != MODE_DAYS_DROP);
            count_next  = '0;
            sum_next    = '0;
            high_next   = SEED_HIGH;
            low_next    = SEED_LOW;
            kig_next    = '0;
            active_next = 1'b0;
            hp_next     = 1'b0;
        end
        else if (year_ok)
        begin
            count_next  = count_after;
            sum_next    = sum_after;
            high_next   = high_after;
            low_next    = low_after;
            active_next = 1'b1;
            date_next   = base_active ? date_reg : date_in;
            if (key_mode)
            begin
                close    = key_close;
                key_next = key;
                if (!base_active)
                    kig_next = KIG_W'(1);
                else if (key_change && (kig_reg < KIG_MAX))
                    kig_next = kig_reg + 1'b1;
            end
            else if (count_close)
            begin
                close       = 1'b1;
                snap_sum    = sum_after;
                snap_count  = count_after;
                snap_high   = high_after;
                snap_low    = low_after;
                snap_date   = date_next;
                count_next  = '0;
                sum_next    = '0;
                high_next   = SEED_HIGH;
                low_next    = SEED_LOW;
                kig_next    = '0;
                active_next = 1'b0;
            end
            if (close)
                hp_next = 1'b1;
        end

        snap_mag = snap_sum[SUM_W-1] ? (~snap_sum + 1'b1) : snap_sum;
    end

    assign div_start = cmd_ctl.step && close;

    ohlc_div #(
        .CW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (snap_mag),
        .divisor  (snap_count),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        if (snap_zero_reg)
            mean32 = '0;
        else if (snap_neg_reg)
            mean32 = ~quotient + 1'b1;
        else
            mean32 = quotient;
        mean16 = mean32[TEMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            high_reg      <= SEED_HIGH;
            low_reg       <= SEED_LOW;
            kig_reg       <= '0;
            key_reg       <= '0;
            date_reg      <= '0;
            active_reg    <= 1'b0;
            hp_reg        <= 1'b0;
            prev_mean_reg <= '0;
        end
        else
        begin
            if (cmd_ctl.step)
            begin
                count_reg  <= count_next;
                sum_reg    <= sum_next;
                high_reg   <= high_next;
                low_reg    <= low_next;
                kig_reg    <= kig_next;
                key_reg    <= key_next;
                date_reg   <= date_next;
                active_reg <= active_next;
                hp_reg     <= hp_next;
            end
            if (cmd_ctl.out_load)
                prev_mean_reg <= mean16;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            snap_hp_reg   <= hp_reg;
            snap_neg_reg  <= snap_sum[SUM_W-1];
            snap_zero_reg <= (snap_count == '0);
            snap_date_reg <= snap_date;
            snap_high_reg <= snap_high;
            snap_low_reg  <= snap_low;
        end
        if (cmd_ctl.out_load)
        begin
            first_year_reg  <= snap_date_reg[DATE_W-1 -: YEAR_W];
            first_month_reg <= snap_date_reg[DAY_W +: MONTH_W];
            first_day_reg   <= snap_date_reg[DAY_W-1:0];
            open_reg        <= snap_hp_reg ? prev_mean_reg : mean16;
            close_reg       <= mean16;
            high_out_reg    <= snap_high_reg;
            low_out_reg     <= snap_low_reg;
        end
    end

    assign status.close    = close;
    assign status.div_done = div_done;

    assign first_year  = first_year_reg;
    assign first_month = first_month_reg;
    assign first_day   = first_day_reg;
    assign open_mean   = open_reg;
    assign close_mean  = close_reg;
    assign high_value  = high_out_reg;
    assign low_value   = low_out_reg;

endmodule

// ----- rtl/ohlc_ctrl.sv -----
// Controller: request sequencing, divider wait and result handoff.
module ohlc_ctrl
    import ohlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd_ctl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd_ctl.step     = (state_reg == ST_IDLE) && in_valid;
        cmd_ctl.out_load = (state_reg == ST_WRITE) && (!out_valid_reg || !out_stall);

        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_ctl.step && status.close)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (cmd_ctl.out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- tb/tb_ohlc_window_aggregator.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for ohlc_window_aggregator: directed table, then random date streams.
module tb_ohlc_window_aggregator;
    import ohlc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int ITEM_TARGET   = 1900;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;
    localparam logic [MODE_W-1:0] MODE_SPARE_TOP = 3'd7;

    typedef struct packed {
        logic [YEAR_W-1:0]        first_year;
        logic [MONTH_W-1:0]       first_month;
        logic [DAY_W-1:0]         first_day;
        logic signed [TEMP_W-1:0] open_mean;
        logic signed [TEMP_W-1:0] close_mean;
        logic signed [TEMP_W-1:0] high_value;
        logic signed [TEMP_W-1:0] low_value;
    } candle_t;

    typedef struct {
        logic    c;
        int      t;
        int      y;
        int      m;
        int      d;
        bit      has_exp;
        candle_t exp_c;
    } dir_row_t;

    typedef struct {
        logic [MODE_W-1:0] mode;
        int                size;
        int                yr_first;
        int                yr_last;
    } phase_cfg_t;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_AW-1:0]        paddr;
    logic [APB_DW-1:0]        pwdata;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_stall;
    logic                     cmd;
    logic signed [TEMP_W-1:0] temperature;
    logic [YEAR_W-1:0]        sample_year;
    logic [MONTH_W-1:0]       sample_month;
    logic [DAY_W-1:0]         sample_day;
    logic                     out_valid;
    logic                     out_stall;
    logic [YEAR_W-1:0]        first_year;
    logic [MONTH_W-1:0]       first_month;
    logic [DAY_W-1:0]         first_day;
    logic signed [TEMP_W-1:0] open_mean;
    logic signed [TEMP_W-1:0] close_mean;
    logic signed [TEMP_W-1:0] high_value;
    logic signed [TEMP_W-1:0] low_value;

    ohlc_window_aggregator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .temperature  (temperature),
        .sample_year  (sample_year),
        .sample_month (sample_month),
        .sample_day   (sample_day),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .first_year   (first_year),
        .first_month  (first_month),
        .first_day    (first_day),
        .open_mean    (open_mean),
        .close_mean   (close_mean),
        .high_value   (high_value),
        .low_value    (low_value)
    );

    // register mirror
    logic [MODE_W-1:0] cfg_mode;
    logic [SIZE_W-1:0] cfg_size;
    logic [YEAR_W-1:0] cfg_start;
    logic [YEAR_W-1:0] cfg_end;

    // candle accumulator state
    int                grp_count;
    int                grp_sum;
    int                grp_high;
    int                grp_low;
    int                prev_mean;
    bit                prev_valid;
    int                key_count;
    int                cur_key;
    bit                grp_open;
    logic [YEAR_W-1:0] grp_y;
    logic [MONTH_W-1:0] grp_m;
    logic [DAY_W-1:0]  grp_d;

    // date cursor for stimulus
    int cur_y;
    int cur_m;
    int cur_d;
    int yr_lo;
    int yr_hi;

    candle_t candle_q[$];
    int      err_count   = 0;
    int      cycle_count = 0;
    bit      no_idle     = 1'b0;

    // years mode, size 1: a new year closes the open group
    dir_row_t dir_rows[13] = '{
        '{CMD_SAMPLE, 20000, 0, 1, 1, 1'b0, '0},
        '{CMD_SAMPLE, -20000, 0, 12, 31, 1'b0, '0},
        '{CMD_SAMPLE, 5, 1, 1, 1, 1'b1,
          '{14'd0, 4'd1, 5'd1, 16'sd0, 16'sd0, 16'sd20000, -16'sd20000}},
        '{CMD_FLUSH, 0, 0, 1, 1, 1'b1,
          '{14'd1, 4'd1, 5'd1, 16'sd0, 16'sd5, 16'sd5, 16'sd5}},
        '{CMD_FLUSH, -1, 9999, 15, 31, 1'b0, '0},
        '{CMD_SAMPLE, -1, 9999, 15, 0, 1'b0, '0},
        '{CMD_SAMPLE, -4, 9999, 15, 31, 1'b0, '0},
        '{CMD_SAMPLE, 0, 9998, 1, 1, 1'b1,
          '{14'd9999, 4'd15, 5'd0, -16'sd2, -16'sd2, -16'sd1, -16'sd4}},
        '{CMD_SAMPLE, 7, 9999, 1, 1, 1'b1,
          '{14'd9998, 4'd1, 5'd1, -16'sd2, 16'sd0, 16'sd0, 16'sd0}},
        '{CMD_FLUSH, 0, 0, 1, 1, 1'b1,
          '{14'd9999, 4'd1, 5'd1, 16'sd0, 16'sd7, 16'sd7, 16'sd7}},
        '{CMD_SAMPLE, 1234, 5000, 6, 15, 1'b0, '0},
        '{CMD_SAMPLE, -4321, 5000, 7, 2, 1'b0, '0},
        '{CMD_SAMPLE, 100, 5001, 1, 1, 1'b0, '0}
    };

    phase_cfg_t fixed_phases[7] = '{
        '{MODE_DAYS, 1, 0, 9999},
        '{MODE_WEEKS, 1, 0, 9999},
        '{MODE_MONTHS, 9, 0, 9999},
        '{MODE_YEARS, 0, 9990, 9999},
        '{MODE_SPARE_TOP, 2, 0, 9999},
        '{MODE_MONTHS, 2, 9999, 9999},
        '{MODE_DAYS_DROP, 9, 9999, 0}
    };

    function automatic void grp_clear();
        grp_count = 0;
        grp_sum   = 0;
        grp_high  = SEED_HIGH;
        grp_low   = SEED_LOW;
        key_count = 0;
        grp_open  = 1'b0;
    endfunction

    function automatic void grp_add(input int t, input logic [YEAR_W-1:0] y,
                                    input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d);
        longint s;
        if (!grp_open) begin
            grp_open = 1'b1;
            grp_y    = y;
            grp_m    = m;
            grp_d    = d;
        end
        if (grp_count < MAX_GROUP_SAMPLES_DEF) begin
            s = longint'(grp_sum) + t;
            if (s > 64'sd2147483647)
                s = 64'sd2147483647;
            if (s < -64'sd2147483648)
                s = -64'sd2147483648;
            grp_sum = int'(s);
            grp_count++;
        end
        if (t > grp_high)
            grp_high = t;
        if (t < grp_low)
            grp_low = t;
    endfunction

    function automatic void grp_close(output candle_t c);
        int mean;
        int open_v;
        mean   = (grp_count != 0) ? grp_sum / grp_count : 0;
        open_v = prev_valid ? prev_mean : mean;
        c.first_year  = grp_y;
        c.first_month = grp_m;
        c.first_day   = grp_d;
        c.open_mean   = open_v[15:0];
        c.close_mean  = mean[15:0];
        c.high_value  = grp_high[15:0];
        c.low_value   = grp_low[15:0];
        prev_mean  = mean;
        prev_valid = 1'b1;
        grp_clear();
    endfunction

    // returns 1 when the request closes a candle
    function automatic bit candle_predict(input logic c, input logic signed [TEMP_W-1:0] t,
                                          input logic [YEAR_W-1:0] y,
                                          input logic [MONTH_W-1:0] m,
                                          input logic [DAY_W-1:0] d, output candle_t res);
        logic [MODE_W-1:0] mode;
        int size;
        int key_v;
        int target;
        bit hit;
        hit  = 1'b0;
        res  = '0;
        mode = (cfg_mode > MODE_DAYS_DROP) ? MODE_DAYS_DROP : cfg_mode;
        size = (cfg_size == 0) ? 1 : int'(cfg_size);
        if (c == CMD_FLUSH) begin
            if (grp_open && mode != MODE_DAYS_DROP) begin
                grp_close(res);
                hit = 1'b1;
            end else begin
                grp_clear();
            end
            prev_valid = 1'b0;
            return hit;
        end
        if (y < cfg_start || y > cfg_end)
            return 1'b0;
        if (mode == MODE_MONTHS || mode == MODE_YEARS) begin
            key_v = (mode == MODE_MONTHS) ? int'({y, m}) : int'(y);
            if (grp_open && key_v != cur_key) begin
                if (key_count >= size) begin
                    grp_close(res);
                    hit = 1'b1;
                end else if (key_count < KIG_MAX) begin
                    key_count++;
                end
            end
            if (!grp_open)
                key_count = 1;
            cur_key = key_v;
            grp_add(t, y, m, d);
        end else begin
            target = size * ((mode == MODE_WEEKS) ? DAYS_PER_WEEK * HOURS_PER_DAY_DEF
                                                  : HOURS_PER_DAY_DEF);
            if (target > MAX_GROUP_SAMPLES_DEF)
                target = MAX_GROUP_SAMPLES_DEF;
            grp_add(t, y, m, d);
            if (grp_count >= target) begin
                grp_close(res);
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic string fmt_candle(candle_t c);
        return $sformatf("%0d-%0d-%0d open %0d close %0d high %0d low %0d",
                         c.first_year, c.first_month, c.first_day, c.open_mean,
                         c.close_mean, c.high_value, c.low_value);
    endfunction

    function automatic logic signed [TEMP_W-1:0] rand_temp();
        int v;
        case ($urandom_range(0, 15))
            0: v = -20000;
            1: v = 20000;
            2: v = -1;
            3: v = 0;
            default: v = int'($urandom_range(0, 8000)) - 4000;
        endcase
        return v[15:0];
    endfunction

    // level 0 next day, 1 next month, 2 next year
    function automatic void advance_cursor(input int level);
        if (level == 0) begin
            cur_d++;
            if (cur_d > 28 + int'($urandom_range(0, 3))) begin
                cur_d = 1;
                level = 1;
            end
        end
        if (level == 1) begin
            cur_m++;
            if (cur_m > 12) begin
                cur_m = 1;
                level = 2;
            end
        end
        if (level == 2) begin
            cur_y++;
            if (cur_y > yr_hi)
                cur_y = yr_lo;
        end
    endfunction

    function automatic void jump_cursor();
        cur_y = $urandom_range((yr_lo > 2) ? yr_lo - 2 : 0, (yr_hi < 9997) ? yr_hi + 2 : 9999);
        if ($urandom_range(0, 9) == 0) begin
            cur_m = $urandom_range(0, 15);
            cur_d = $urandom_range(0, 31);
        end else begin
            cur_m = $urandom_range(1, 12);
            cur_d = $urandom_range(1, 28);
        end
    endfunction

    task automatic gen_item(output logic c, output logic signed [TEMP_W-1:0] t,
                            output logic [YEAR_W-1:0] y, output logic [MONTH_W-1:0] m,
                            output logic [DAY_W-1:0] d);
        int r;
        r = $urandom_range(0, 99);
        if (cfg_mode == MODE_MONTHS || cfg_mode == MODE_YEARS) begin
            if (r >= 97)
                jump_cursor();
            else if (r >= 88)
                advance_cursor(2);
            else if (r >= 70)
                advance_cursor(1);
            else if (r >= 50)
                advance_cursor(0);
        end else begin
            if (r >= 98)
                jump_cursor();
            else if ($urandom_range(0, 23) == 0)
                advance_cursor(0);
        end
        c = ($urandom_range(0, 49) == 0) ? CMD_FLUSH : CMD_SAMPLE;
        t = rand_temp();
        y = cur_y[13:0];
        m = cur_m[3:0];
        d = cur_d[4:0];
    endtask

    task automatic reg_write(input logic [1:0] idx, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_GROUP_MODE: cfg_mode  = val[MODE_W-1:0];
            REG_GROUP_SIZE: cfg_size  = val[SIZE_W-1:0];
            REG_START_YEAR: cfg_start = val[YEAR_W-1:0];
            REG_END_YEAR:   cfg_end   = val[YEAR_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_phase(input phase_cfg_t pc);
        reg_write(REG_GROUP_MODE, pc.mode);
        reg_write(REG_GROUP_SIZE, pc.size);
        reg_write(REG_START_YEAR, pc.yr_first);
        reg_write(REG_END_YEAR, pc.yr_last);
    endtask

    task automatic wait_drained();
        while (candle_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_item(input logic c, input logic signed [TEMP_W-1:0] t,
                             input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                             input logic [DAY_W-1:0] d);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        temperature  <= t;
        sample_year  <= y;
        sample_month <= m;
        sample_day   <= d;
        do @(posedge clk); while (in_stall);
    endtask

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        candle_t got;
        candle_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{first_year, first_month, first_day, open_mean, close_mean,
                    high_value, low_value};
            if (candle_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected candle: %s", fmt_candle(got));
            end else begin
                want = candle_q.pop_front();
                if (got.first_year !== want.first_year || got.first_month !== want.first_month
                    || got.first_day !== want.first_day || got.open_mean !== want.open_mean
                    || got.close_mean !== want.close_mean
                    || got.high_value !== want.high_value
                    || got.low_value !== want.low_value) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("candle mismatch: exp %s, got %s",
                                 fmt_candle(want), fmt_candle(got));
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 12);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        phase_cfg_t                pc;
        candle_t                   pred;
        logic                      c;
        logic signed [TEMP_W-1:0]  t;
        logic [YEAR_W-1:0]         y;
        logic [MONTH_W-1:0]        m;
        logic [DAY_W-1:0]          d;
        bit                        hit;
        int                        total;
        int                        quota;
        int                        tries;
        int                        count;
        int                        phase_n;

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        cmd          = CMD_SAMPLE;
        temperature  = '0;
        sample_year  = '0;
        sample_month = '0;
        sample_day   = '0;

        cfg_mode   = MODE_DAYS;
        cfg_size   = GROUP_SIZE_RST;
        cfg_start  = '0;
        cfg_end    = END_YEAR_RST;
        grp_clear();
        prev_mean  = 0;
        prev_valid = 1'b0;
        cur_key    = 0;
        grp_y      = '0;
        grp_m      = '0;
        grp_d      = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_phase('{MODE_YEARS, 1, 0, 9999});
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].c, dir_rows[i].t[15:0], dir_rows[i].y[13:0],
                      dir_rows[i].m[3:0], dir_rows[i].d[4:0]);
            hit = candle_predict(dir_rows[i].c, dir_rows[i].t[15:0], dir_rows[i].y[13:0],
                                 dir_rows[i].m[3:0], dir_rows[i].d[4:0], pred);
            if (dir_rows[i].has_exp)
                candle_q.insert(candle_q.size(), dir_rows[i].exp_c);
            else if (hit)
                candle_q.insert(candle_q.size(), pred);
        end

        total   = 0;
        phase_n = 0;
        while (total < ITEM_TARGET) begin
            if (phase_n < $size(fixed_phases)) begin
                pc    = fixed_phases[phase_n];
                quota = 120;
            end else begin
                pc.mode = MODE_W'($urandom_range(0, 7));
                if (pc.mode == MODE_MONTHS || pc.mode == MODE_YEARS)
                    pc.size = $urandom_range(0, 9);
                else if (pc.mode == MODE_WEEKS)
                    pc.size = $urandom_range(0, 1);
                else
                    pc.size = $urandom_range(0, 3);
                if ($urandom_range(0, 9) == 0) begin
                    pc.yr_first = $urandom_range(5000, 9999);
                    pc.yr_last  = $urandom_range(0, 4999);
                end else begin
                    pc.yr_first = $urandom_range(0, 9950);
                    pc.yr_last  = pc.yr_first + int'($urandom_range(0, 40));
                end
                quota = $urandom_range(100, 200);
            end
            phase_n++;

            // registers change only with nothing in flight
            in_valid <= 1'b0;
            @(posedge clk);
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            apply_phase(pc);

            no_idle = ($urandom_range(0, 3) == 0);
            if (pc.yr_first <= pc.yr_last) begin
                yr_lo = pc.yr_first;
                yr_hi = pc.yr_last;
            end else begin
                yr_lo = 0;
                yr_hi = 9999;
            end
            cur_y = yr_lo;
            cur_m = $urandom_range(1, 12);
            cur_d = 1;

            tries = 0;
            count = 0;
            while (count < quota && tries < quota + 80 && total + tries < ITEM_TARGET) begin
                tries++;
                gen_item(c, t, y, m, d);
                if (c == CMD_FLUSH || (y >= cfg_start && y <= cfg_end))
                    count++;
                if ($urandom_range(0, 99) == 0) begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    wait_drained();
                end
                send_item(c, t, y, m, d);
                if (candle_predict(c, t, y, m, d, pred))
                    candle_q.insert(candle_q.size(), pred);
            end
            total += tries;
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ohlc_pkg.sv
rtl/ohlc_div.sv
rtl/ohlc_dp.sv
rtl/ohlc_ctrl.sv
rtl/ohlc_window_aggregator.sv
tb/tb_ohlc_window_aggregator.sv
